/* hdl/prwb_pkg.sv */
// ----------------------------------------------------------------------------
// prwb_pkg
// Shared types and constants for the perfect-reflector white balance block.
// ----------------------------------------------------------------------------
`default_nettype none
package prwb_pkg;
   localparam int MAX_PIXELS_DEF = 4096;
   localparam int SUM_BINS       = 766;
   localparam int SUM_TOP        = 765;
   localparam int SUM_W          = 10;
   localparam int HIST_AW        = 10;
   localparam int SHARE_W        = 7;
   localparam int SHARE_RESET    = 10;
   localparam int PIX_W          = 24;

   typedef enum logic [3:0] {
      ST_IDLE,      // loading / fetching
      ST_CLEAR,     // histogram clearing pass
      ST_SCAN_RD,   // histogram tail scan, read issue
      ST_SCAN_CHK,  // histogram tail scan, check
      ST_SUM,       // sweep store, accumulate bright pixels
      ST_DIV,       // averages by restoring division
      ST_READY      // fetches allowed
   } state_type;
endpackage
`default_nettype wire

/* hdl/prwb_ram.sv */
// ----------------------------------------------------------------------------
// prwb_ram
// Generic single-port-write, one-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module prwb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hdl/prwb_div.sv */
// ----------------------------------------------------------------------------
// prwb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module prwb_div #(
   parameter int NW = 20,
   parameter int DW = 13
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          go,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic      [NW-1:0] quot
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quot_ff, quot_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DW-1:0], quot_ff[NW-1]};
      if (go) begin
         quot_in = num;
         rem_in  = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den}) begin
            rem_in  = trial - {1'b0, den};
            quot_in = {quot_ff[NW-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule
`default_nettype wire

/* hdl/perfect_reflector_white_balance.sv */
// ----------------------------------------------------------------------------
// perfect_reflector_white_balance
// Frame-based perfect-reflector white balance over BGR pixels.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: a transaction is taken when start is high and busy is low.
//    req_mode 0 loads a pixel (one per cycle while busy is low), req_mode
//    1 fetches the next corrected pixel of the closed frame.
//  - A load with req_frame_end set closes the frame. busy then stays high
//    for the compute pause: a histogram scan down from the top bin, a
//    sweep of the frame store and three divisions for the channel averages.
//  - A fetch that finds a pixel answers with rsp_valid for exactly one
//    cycle; one fetch runs at a time, and busy stays high while it waits
//    on the store's registered read and three parallel 16-step dividers
//    for channel * peak / average.
//  - The receiver cannot stall; results are never held.
//  - The first load of each frame starts a histogram clearing pass over
//    every bin; the pixel is held meanwhile and stored at its end.
//  - csr_ carries bright_share_percent (reset 10), written when the block is
//    idle.
//  - Reset clears most control state; the frame store is left undefined.
// ----------------------------------------------------------------------------
`default_nettype none
module perfect_reflector_white_balance #(
   parameter int MAX_PIXELS = prwb_pkg::MAX_PIXELS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_mode,
   input  wire logic [7:0] req_blue,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_red,
   input  wire logic       req_frame_end,
   output logic            rsp_valid,
   output logic [7:0]      rsp_blue_out,
   output logic [7:0]      rsp_green_out,
   output logic [7:0]      rsp_red_out,
   output logic            rsp_final_pixel,
   output logic            rsp_fault,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [6:0] csr_data
);
   localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CNW = $clog2(MAX_PIXELS + 1);
   localparam int SW  = CNW + 8;                 // channel sum width
   localparam int HW  = CNW;                     // histogram counter width
   localparam int TW  = CNW + 7;                 // tail*100 / need width
   localparam int HAW = prwb_pkg::HIST_AW;

   // ------------------------------------------------------------------ state
   prwb_pkg::state_type state_ff, state_in;

   logic [6:0]     share_ff, share_in;
   logic [CNW-1:0] count_ff, count_in;
   logic [CNW-1:0] rdptr_ff, rdptr_in;
   logic [7:0]     peak_ff, peak_in;
   logic           ovf_ff, ovf_in;
   logic           ready_ff, ready_in;     // frame closed, gains valid
   logic           started_ff, started_in; // frame open (histogram cleared)
   logic [HAW-1:0] hidx_ff, hidx_in;       // clear/scan bin index
   logic [CNW-1:0] tail_ff, tail_in;
   logic [9:0]     thr_ff, thr_in;
   logic [CNW-1:0] sidx_ff, sidx_in;       // store sweep index
   logic           sval_ff, sval_in;       // store read data valid next cycle
   logic [SW-1:0]  sum_ff [3];
   logic [SW-1:0]  sum_in [3];
   logic [CNW-1:0] bcnt_ff, bcnt_in;
   logic [1:0]     dch_ff, dch_in;
   logic           dgo_ff, dgo_in;
   logic [7:0]     avg_ff [3];
   logic [7:0]     avg_in [3];
   logic [23:0]    ppix_ff, ppix_in;       // load held over clearing pass
   logic           pend_end_ff, pend_end_in;
   // fetch pipeline
   logic           f1_ff, f1_in;
   logic           f1_last_ff, f1_last_in;
   logic           ow_ff, ow_in;           // output division running
   logic           olast_ff;
   logic [23:0]    opix_ff;                // stored pixel, passed on a fault
   logic           ofault_ff;

   // --------------------------------------------------------------- memories
   logic           st_we;
   logic [AW-1:0]  st_wa, st_ra;
   logic [23:0]    st_wd, st_rd;
   logic           h_we;
   logic [HAW-1:0] h_wa, h_ra;
   logic [HW-1:0]  h_wd, h_rd;

   prwb_ram #(.WIDTH(prwb_pkg::PIX_W), .DEPTH(MAX_PIXELS)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd));

   prwb_ram #(.WIDTH(HW), .DEPTH(prwb_pkg::SUM_BINS)) u_hist (
      .clock(clock), .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr(h_ra), .rd_data(h_rd));

   // -------------------------------------------------------------- divider
   logic           d_done;
   logic [SW-1:0]  d_quot;
   prwb_div #(.NW(SW), .DW(CNW)) u_div (
      .clock(clock), .reset(reset), .go(dgo_ff), .num(sum_ff[dch_ff]),
      .den(bcnt_ff), .done(d_done), .quot(d_quot));

   // Output stage: channel * peak / average, one divider per channel, all
   // started together on the cycle the stored pixel is read back.
   logic [15:0] o_prod [3];
   logic [15:0] o_quot [3];
   logic [2:0]  o_done;
   logic        o_all_done;

   assign o_prod[0]  = 16'(st_rd[7:0])   * 16'(peak_ff);
   assign o_prod[1]  = 16'(st_rd[15:8])  * 16'(peak_ff);
   assign o_prod[2]  = 16'(st_rd[23:16]) * 16'(peak_ff);
   assign o_all_done = &o_done;

   prwb_div #(.NW(16), .DW(8)) u_odiv_b (
      .clock(clock), .reset(reset), .go(f1_ff), .num(o_prod[0]),
      .den(avg_ff[0]), .done(o_done[0]), .quot(o_quot[0]));

   prwb_div #(.NW(16), .DW(8)) u_odiv_g (
      .clock(clock), .reset(reset), .go(f1_ff), .num(o_prod[1]),
      .den(avg_ff[1]), .done(o_done[1]), .quot(o_quot[1]));

   prwb_div #(.NW(16), .DW(8)) u_odiv_r (
      .clock(clock), .reset(reset), .go(f1_ff), .num(o_prod[2]),
      .den(avg_ff[2]), .done(o_done[2]), .quot(o_quot[2]));

   // ------------------------------------------------------ request decoding
   logic accept, load_acc, fetch_acc;
   assign accept    = start && !busy;
   assign load_acc  = accept && !req_mode;
   assign fetch_acc = accept && req_mode;

   // Load path into histogram uses a read-modify-write: pixel sum is read
   // in the load cycle, incremented in the next cycle. Back-to-back hits on
   // the same bin are forwarded, as are clearing-pass writes.
   logic           lw_ff, lw_in;           // histogram update pending
   logic [HAW-1:0] lw_bin_ff, lw_bin_in;
   logic [HW-1:0]  lw_val;                  // current count of pending bin
   logic [HW-1:0]  fwd_ff, fwd_in;          // last written value
   logic           fwdv_ff, fwdv_in;
   logic [HAW-1:0] fwd_bin_ff, fwd_bin_in;

   assign lw_val = (fwdv_ff && fwd_bin_ff == lw_bin_ff) ? fwd_ff : h_rd;

   // Threshold scan helpers; the top bin may still be in its last update
   // when the scan reads it.
   logic [HW-1:0]  hist_q;
   logic [CNW-1:0] tail_next;
   logic [TW-1:0]  tail100, need;
   assign hist_q    = (fwdv_ff && fwd_bin_ff == hidx_ff) ? fwd_ff : h_rd;
   assign tail_next = tail_ff + hist_q;
   assign tail100   = TW'(tail_next) * TW'(100);
   assign need      = TW'(share_ff) * TW'(count_ff);

   logic [9:0] psum;
   assign psum = 10'(st_rd[7:0]) + 10'(st_rd[15:8]) + 10'(st_rd[23:16]);

   // pixel being stored (direct or held over clearing pass)
   logic        do_store;
   logic [23:0] store_pix;
   logic        store_end;
   logic [9:0]  store_sum;

   // fault for the frame
   logic frame_fault;
   assign frame_fault = ovf_ff || bcnt_ff == '0 || avg_ff[0] == '0 ||
                        avg_ff[1] == '0 || avg_ff[2] == '0;

   // ---------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prwb_pkg::ST_IDLE, prwb_pkg::ST_READY: begin
            if (load_acc && !started_ff) begin
               state_in = prwb_pkg::ST_CLEAR;
            end else if (do_store && store_end || load_acc && req_frame_end) begin
               state_in = prwb_pkg::ST_SCAN_RD;
            end
         end
         prwb_pkg::ST_CLEAR: begin
            // a one-pixel frame closes as soon as its pixel is stored
            if (hidx_ff == HAW'(prwb_pkg::SUM_TOP)) begin
               state_in = pend_end_ff ? prwb_pkg::ST_SCAN_RD : prwb_pkg::ST_IDLE;
            end
         end
         prwb_pkg::ST_SCAN_RD: begin
            state_in = prwb_pkg::ST_SCAN_CHK;
         end
         prwb_pkg::ST_SCAN_CHK: begin
            if (tail100 >= need || hidx_ff == '0) begin
               state_in = prwb_pkg::ST_SUM;
            end else begin
               state_in = prwb_pkg::ST_SCAN_RD;
            end
         end
         prwb_pkg::ST_SUM: begin
            if (sidx_ff >= count_ff && !sval_ff) begin
               state_in = prwb_pkg::ST_DIV;
            end
         end
         prwb_pkg::ST_DIV: begin
            if (d_done && dch_ff == 2'd2) begin
               state_in = prwb_pkg::ST_READY;
            end
         end
         default: state_in = prwb_pkg::ST_IDLE;
      endcase
   end

   // --------------------------------------------------------- datapath
   always_comb begin
      share_in    = share_ff;
      count_in    = count_ff;
      rdptr_in    = rdptr_ff;
      peak_in     = peak_ff;
      ovf_in      = ovf_ff;
      ready_in    = ready_ff;
      started_in  = started_ff;
      hidx_in     = hidx_ff;
      tail_in     = tail_ff;
      thr_in      = thr_ff;
      sidx_in     = sidx_ff;
      sval_in     = 1'b0;
      sum_in      = sum_ff;
      bcnt_in     = bcnt_ff;
      dch_in      = dch_ff;
      dgo_in      = 1'b0;
      avg_in      = avg_ff;
      ppix_in     = ppix_ff;
      pend_end_in = pend_end_ff;
      f1_in       = 1'b0;
      f1_last_in  = 1'b0;
      ow_in       = ow_ff;
      lw_in       = 1'b0;
      lw_bin_in   = lw_bin_ff;
      fwd_in      = fwd_ff;
      fwdv_in     = 1'b0;
      fwd_bin_in  = fwd_bin_ff;
      st_we = 1'b0;
      st_wa = count_ff[AW-1:0];
      st_wd = '0;
      st_ra = rdptr_ff[AW-1:0];
      h_we  = 1'b0;
      h_wa  = lw_bin_ff;
      h_wd  = lw_val + 1'b1;
      h_ra  = hidx_ff;
      do_store  = 1'b0;
      store_pix = {req_red, req_green, req_blue};
      store_end = req_frame_end;
      store_sum = '0;

      if (csr_valid && csr_ready) begin
         share_in = csr_data;
      end

      // pending histogram increment
      if (lw_ff) begin
         h_we       = 1'b1;
         fwd_in     = lw_val + 1'b1;
         fwdv_in    = 1'b1;
         fwd_bin_in = lw_bin_ff;
      end

      // output division in flight until all three channels are done
      if (f1_ff) begin
         ow_in = 1'b1;
      end else if (o_all_done) begin
         ow_in = 1'b0;
      end

      case (state_ff)
         prwb_pkg::ST_CLEAR: begin
            h_we       = 1'b1;
            h_wa       = hidx_ff;
            h_wd       = '0;
            fwd_in     = '0;
            fwdv_in    = 1'b1;
            fwd_bin_in = hidx_ff;
            hidx_in    = hidx_ff + 1'b1;
            if (hidx_ff == HAW'(prwb_pkg::SUM_TOP)) begin
               do_store  = 1'b1;
               store_pix = ppix_ff;
               store_end = pend_end_ff;
            end
         end
         prwb_pkg::ST_SCAN_RD: begin
            h_ra = hidx_ff;
         end
         prwb_pkg::ST_SCAN_CHK: begin
            tail_in = tail_next;
            if (tail100 >= need || hidx_ff == '0) begin
               thr_in  = (tail100 >= need) ? hidx_ff : 10'd0;
               sidx_in = '0;
               sum_in  = '{default: '0};
               bcnt_in = '0;
            end else begin
               hidx_in = hidx_ff - 1'b1;
            end
         end
         prwb_pkg::ST_SUM: begin
            st_ra = sidx_ff[AW-1:0];
            if (sidx_ff < count_ff) begin
               sidx_in = sidx_ff + 1'b1;
               sval_in = 1'b1;
            end
            if (sval_ff && psum > thr_ff) begin
               bcnt_in   = bcnt_ff + 1'b1;
               sum_in[0] = sum_ff[0] + SW'(st_rd[7:0]);
               sum_in[1] = sum_ff[1] + SW'(st_rd[15:8]);
               sum_in[2] = sum_ff[2] + SW'(st_rd[23:16]);
            end
            if (sidx_ff >= count_ff && !sval_ff) begin
               dch_in = 2'd0;
               dgo_in = 1'b1;
            end
         end
         prwb_pkg::ST_DIV: begin
            if (d_done) begin
               avg_in[dch_ff] = (bcnt_ff == '0) ? 8'd0 : d_quot[7:0];
               if (dch_ff != 2'd2) begin
                  dch_in = dch_ff + 1'b1;
                  dgo_in = 1'b1;
               end else begin
                  ready_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      // load transaction
      if (load_acc) begin
         if (!started_ff) begin
            // new frame: reset per-frame state, clear histogram first
            started_in  = 1'b1;
            ready_in    = 1'b0;
            count_in    = '0;
            rdptr_in    = '0;
            peak_in     = '0;
            ovf_in      = 1'b0;
            hidx_in     = '0;
            ppix_in     = {req_red, req_green, req_blue};
            pend_end_in = req_frame_end;
         end else begin
            do_store = 1'b1;
         end
      end

      if (do_store) begin
         store_sum = 10'(store_pix[7:0]) + 10'(store_pix[15:8]) +
                     10'(store_pix[23:16]);
         if (count_in < CNW'(MAX_PIXELS)) begin
            st_we     = 1'b1;
            st_wa     = count_in[AW-1:0];
            st_wd     = store_pix;
            count_in  = count_in + 1'b1;
            h_ra      = store_sum;
            lw_in     = 1'b1;
            lw_bin_in = store_sum;
            if (store_pix[7:0] > peak_in) peak_in = store_pix[7:0];
            if (store_pix[15:8] > peak_in) peak_in = store_pix[15:8];
            if (store_pix[23:16] > peak_in) peak_in = store_pix[23:16];
         end else begin
            ovf_in = 1'b1;
         end
         if (store_end) begin
            started_in = 1'b0;
            hidx_in    = HAW'(prwb_pkg::SUM_TOP);
            tail_in    = '0;
         end
      end

      // fetch transaction
      if (fetch_acc && ready_ff && rdptr_ff < count_ff) begin
         st_ra      = rdptr_ff[AW-1:0];
         rdptr_in   = rdptr_ff + 1'b1;
         f1_in      = 1'b1;
         f1_last_in = (rdptr_ff + 1'b1) == count_ff;
      end
   end

   // quotient saturated to a channel value
   function automatic logic [7:0] sat8(input logic [15:0] q);
      return (q[15:8] != 8'd0) ? 8'd255 : q[7:0];
   endfunction

   // ---------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= prwb_pkg::ST_IDLE;
         share_ff   <= 7'(prwb_pkg::SHARE_RESET);
         count_ff   <= '0;
         rdptr_ff   <= '0;
         peak_ff    <= '0;
         ovf_ff     <= 1'b0;
         ready_ff   <= 1'b0;
         started_ff <= 1'b0;
         sval_ff    <= 1'b0;
         dgo_ff     <= 1'b0;
         f1_ff      <= 1'b0;
         ow_ff      <= 1'b0;
         lw_ff      <= 1'b0;
         fwdv_ff    <= 1'b0;
         thr_ff     <= '0;
         bcnt_ff    <= '0;
         avg_ff     <= '{default: '0};
         sum_ff     <= '{default: '0};
      end else begin
         state_ff   <= state_in;
         share_ff   <= share_in;
         count_ff   <= count_in;
         rdptr_ff   <= rdptr_in;
         peak_ff    <= peak_in;
         ovf_ff     <= ovf_in;
         ready_ff   <= ready_in;
         started_ff <= started_in;
         sval_ff    <= sval_in;
         dgo_ff     <= dgo_in;
         f1_ff      <= f1_in;
         ow_ff      <= ow_in;
         lw_ff      <= lw_in;
         fwdv_ff    <= fwdv_in;
         thr_ff     <= thr_in;
         bcnt_ff    <= bcnt_in;
         avg_ff     <= avg_in;
         sum_ff     <= sum_in;
      end
      hidx_ff     <= hidx_in;
      tail_ff     <= tail_in;
      sidx_ff     <= sidx_in;
      dch_ff      <= dch_in;
      ppix_ff     <= ppix_in;
      pend_end_ff <= pend_end_in;
      lw_bin_ff   <= lw_bin_in;
      fwd_ff      <= fwd_in;
      fwd_bin_ff  <= fwd_bin_in;
      f1_last_ff  <= f1_last_in;
      if (f1_ff) begin
         ofault_ff <= frame_fault;
         opix_ff   <= st_rd;
         olast_ff  <= f1_last_ff;
      end
   end

   // busy: held through clearing pass and compute, and while a fetch is
   // in flight.
   assign busy = !(state_ff == prwb_pkg::ST_IDLE || state_ff == prwb_pkg::ST_READY)
                 || f1_ff || ow_ff;
   assign csr_ready = !busy;

   assign rsp_valid       = o_all_done;
   assign rsp_blue_out    = ofault_ff ? opix_ff[7:0]   : sat8(o_quot[0]);
   assign rsp_green_out   = ofault_ff ? opix_ff[15:8]  : sat8(o_quot[1]);
   assign rsp_red_out     = ofault_ff ? opix_ff[23:16] : sat8(o_quot[2]);
   assign rsp_final_pixel = olast_ff;
   assign rsp_fault       = ofault_ff;
endmodule
`default_nettype wire
